FILE: rtl/ust_pkg.sv
package ust_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int DATA_W   = 32;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MOVE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

FILE: rtl/unordered_set_table.sv
// Set of distinct signed 32-bit values held in an unordered 1024-entry table.
// Input channel (in_valid/in_ready, kind, value): kind 0 adds value, kind 1
// removes it. Output channel (out_valid/out_ready, ok, count): one result per
// input transfer, ok set when the table changed, count the fill afterwards.
// Each operation scans the filled entries one per cycle through the single
// read port of the table memory. An operation on an empty table skips the
// scan, and a remove that finds its value then moves the last entry into the
// freed slot before the result is registered.
// One operation is in flight at a time; a new input transfer is taken in the
// cycle after the previous result enters the output register.
// Reset clears the fill count and the output valid; the table memory is not
// cleared, since only entries below the fill count are ever read.
// When the receiver stalls, the result holds in the output register; the next
// operation runs but waits in its final cycle until the register is free.
module unordered_set_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [ust_pkg::CNT_W-1:0]     count
);

    ust_pkg::mem_req_t             mem_req;
    logic [ust_pkg::DATA_W-1:0]    mem_rd_data;

    ust_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    ust_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .count       (count),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

endmodule

FILE: rtl/ust_mem.sv
module ust_mem (
    input  logic                          clk,
    input  ust_pkg::mem_req_t             req,
    output logic [ust_pkg::DATA_W-1:0]    rd_data
);

    logic [ust_pkg::DATA_W-1:0] mem [ust_pkg::CAPACITY];
    logic [ust_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/ust_ctrl.sv
module ust_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          ok,
    output logic [ust_pkg::CNT_W-1:0]     count,
    output ust_pkg::mem_req_t             mem_req,
    input  logic [ust_pkg::DATA_W-1:0]    mem_rd_data
);

    ust_pkg::state_t               state_reg, state_next;
    logic                          kind_reg, kind_next;
    logic [ust_pkg::DATA_W-1:0]    value_reg, value_next;
    logic [ust_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [ust_pkg::ADDR_W-1:0]    pos_reg, pos_next;
    logic [ust_pkg::CNT_W-1:0]     fill_reg, fill_next;
    logic                          res_ok_reg, res_ok_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          ok_reg, ok_next;
    logic [ust_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          hit;
    logic                          last;
    logic                          room;

    assign hit  = (mem_rd_data == value_reg);
    assign last = ((ust_pkg::CNT_W'(idx_reg) + ust_pkg::CNT_W'(1)) == fill_reg);
    assign room = (fill_reg < ust_pkg::CNT_W'(ust_pkg::CAPACITY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ust_pkg::ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        res_ok_reg <= res_ok_next;
        ok_reg     <= ok_next;
        count_reg  <= count_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        res_ok_next    = res_ok_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        count_next     = count_reg;
        in_ready       = 1'b0;
        mem_req        = '0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ust_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next  = kind;
                    value_next = value;
                    idx_next   = '0;
                    if (fill_reg == '0)
                    begin
                        if (kind == ust_pkg::KIND_ADD)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = '0;
                            mem_req.wr_data = value;
                            fill_next       = ust_pkg::CNT_W'(1);
                            res_ok_next     = 1'b1;
                        end
                        else
                        begin
                            res_ok_next = 1'b0;
                        end
                        state_next = ust_pkg::ST_FINISH;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        state_next      = ust_pkg::ST_SEARCH;
                    end
                end
            end
            ust_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    if (kind_reg == ust_pkg::KIND_REMOVE)
                    begin
                        pos_next        = idx_reg;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ust_pkg::ADDR_W'(fill_reg - ust_pkg::CNT_W'(1));
                        state_next      = ust_pkg::ST_MOVE;
                    end
                    else
                    begin
                        res_ok_next = 1'b0;
                        state_next  = ust_pkg::ST_FINISH;
                    end
                end
                else if (last)
                begin
                    if (kind_reg == ust_pkg::KIND_ADD && room)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = ust_pkg::ADDR_W'(fill_reg);
                        mem_req.wr_data = value_reg;
                        fill_next       = fill_reg + ust_pkg::CNT_W'(1);
                        res_ok_next     = 1'b1;
                    end
                    else
                    begin
                        res_ok_next = 1'b0;
                    end
                    state_next = ust_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next        = idx_reg + ust_pkg::ADDR_W'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg + ust_pkg::ADDR_W'(1);
                end
            end
            ust_pkg::ST_MOVE:
            begin
                // last entry fills the freed slot
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = mem_rd_data;
                fill_next       = fill_reg - ust_pkg::CNT_W'(1);
                res_ok_next     = 1'b1;
                state_next      = ust_pkg::ST_FINISH;
            end
            ust_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = res_ok_reg;
                    count_next     = fill_reg;
                    state_next     = ust_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ust_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign count     = count_reg;

endmodule
